// ===== hw/rtl/tun_pkg.sv =====
// ----------------------------------------------------------------------------
// tun_pkg
// Shared constants and the pipeline side-data type for the triangle unit normal block.
// ----------------------------------------------------------------------------
`default_nettype none

package tun_pkg;

    // largest normalized magnitude lands in [2^(NORM_TOP-1), 2^NORM_TOP)
    localparam int NORM_TOP = 30;
    localparam int MAG_W    = NORM_TOP;
    localparam int SQ_W     = 2 * MAG_W;
    localparam int SUM_W    = 2 * NORM_TOP + 2;
    localparam int ROOT_W   = SUM_W / 2;
    localparam int REM_W    = ROOT_W + 3;

    // per-transaction side data carried down the pipeline
    typedef struct packed {
        logic                  valid;
        logic                  degen;
        logic [2:0]            neg;
        logic [2:0][MAG_W-1:0] mag;
    } tun_norm_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tun_cross.sv =====
// ----------------------------------------------------------------------------
// tun_cross
// Edge vectors, partial products and cross product magnitude/sign (3 stages).
// ----------------------------------------------------------------------------
`default_nettype none

module tun_cross #(
    parameter int COORD_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           adv,
    input  logic                           in_valid,
    input  logic signed [COORD_BITS-1:0]   a_x,
    input  logic signed [COORD_BITS-1:0]   a_y,
    input  logic signed [COORD_BITS-1:0]   a_z,
    input  logic signed [COORD_BITS-1:0]   b_x,
    input  logic signed [COORD_BITS-1:0]   b_y,
    input  logic signed [COORD_BITS-1:0]   b_z,
    input  logic signed [COORD_BITS-1:0]   c_x,
    input  logic signed [COORD_BITS-1:0]   c_y,
    input  logic signed [COORD_BITS-1:0]   c_z,
    output logic                           cr_valid,
    output logic [2:0]                     cr_neg,
    output logic [2:0][2*COORD_BITS+2:0]   cr_mag
);
    import tun_pkg::*;

    localparam int EW = COORD_BITS + 1;
    localparam int PW = 2 * EW;
    localparam int XW = 2 * COORD_BITS + 3;

    logic                 v1_reg, v2_reg, v3_reg;
    logic signed [EW-1:0] ex_reg, ey_reg, ez_reg, fx_reg, fy_reg, fz_reg;
    logic signed [PW-1:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg, p5_reg;
    logic signed [XW-1:0] cr0, cr1, cr2;
    logic [2:0]           neg_next, neg_reg;
    logic [2:0][XW-1:0]   mag_next, mag_reg;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // stage 1: edge vectors a-b and a-c
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ex_reg <= EW'(a_x) - EW'(b_x);
            ey_reg <= EW'(a_y) - EW'(b_y);
            ez_reg <= EW'(a_z) - EW'(b_z);
            fx_reg <= EW'(a_x) - EW'(c_x);
            fy_reg <= EW'(a_y) - EW'(c_y);
            fz_reg <= EW'(a_z) - EW'(c_z);
        end
    end

    // stage 2: six partial products
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p0_reg <= PW'(ey_reg) * PW'(fz_reg);
            p1_reg <= PW'(ez_reg) * PW'(fy_reg);
            p2_reg <= PW'(ez_reg) * PW'(fx_reg);
            p3_reg <= PW'(ex_reg) * PW'(fz_reg);
            p4_reg <= PW'(ex_reg) * PW'(fy_reg);
            p5_reg <= PW'(ey_reg) * PW'(fx_reg);
        end
    end

    // stage 3: cross product split into sign and magnitude
    always_comb
    begin
        cr0 = XW'(p0_reg) - XW'(p1_reg);
        cr1 = XW'(p2_reg) - XW'(p3_reg);
        cr2 = XW'(p4_reg) - XW'(p5_reg);
        neg_next = {cr2[XW-1], cr1[XW-1], cr0[XW-1]};
        mag_next[0] = cr0[XW-1] ? XW'(-cr0) : XW'(cr0);
        mag_next[1] = cr1[XW-1] ? XW'(-cr1) : XW'(cr1);
        mag_next[2] = cr2[XW-1] ? XW'(-cr2) : XW'(cr2);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            neg_reg <= neg_next;
            mag_reg <= mag_next;
        end
    end

    assign cr_valid = v3_reg;
    assign cr_neg   = neg_reg;
    assign cr_mag   = mag_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/tun_norm.sv =====
// ----------------------------------------------------------------------------
// tun_norm
// Common normalizing shift of the three magnitudes and sum of squares
// (5 stages: max, bit length, shift, square, sum).
// ----------------------------------------------------------------------------
`default_nettype none

module tun_norm #(
    parameter int COORD_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              adv,
    input  logic                              cr_valid,
    input  logic [2:0]                        cr_neg,
    input  logic [2:0][2*COORD_BITS+2:0]      cr_mag,
    output tun_pkg::tun_norm_t                nv,
    output logic [tun_pkg::SUM_W-1:0]         sum
);
    import tun_pkg::*;

    localparam int XW  = 2 * COORD_BITS + 3;
    localparam int BLW = $clog2(XW + 1);
    localparam int WW  = XW + NORM_TOP;

    function automatic logic [BLW-1:0] bit_len(input logic [XW-1:0] v);
        logic [BLW-1:0] n;
        n = '0;
        for (int i = 0; i < XW; i++)
        begin
            if (v[i])
                n = BLW'(i + 1);
        end
        return n;
    endfunction

    logic                 v4_reg, v5_reg;
    logic [2:0]           neg4_reg, neg5_reg;
    logic [2:0][XW-1:0]   mag4_reg, mag5_reg;
    logic [XW-1:0]        mx_next, mx4_reg;
    logic [BLW-1:0]       bl5_reg;
    logic                 degen5_reg;
    logic [WW-1:0]        wide [3];
    tun_norm_t            side6_next, side6_reg, side7_reg, side8_reg;
    logic [SQ_W-1:0]      sq7_reg [3];
    logic [SUM_W-1:0]     sum8_reg;

    // control and side data registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg    <= 1'b0;
            v5_reg    <= 1'b0;
            side6_reg <= '0;
            side7_reg <= '0;
            side8_reg <= '0;
        end
        else if (adv)
        begin
            v4_reg    <= cr_valid;
            v5_reg    <= v4_reg;
            side6_reg <= side6_next;
            side7_reg <= side6_reg;
            side8_reg <= side7_reg;
        end
    end

    // stage 4: largest magnitude
    always_comb
    begin
        mx_next = cr_mag[0];
        if (cr_mag[1] > mx_next)
            mx_next = cr_mag[1];
        if (cr_mag[2] > mx_next)
            mx_next = cr_mag[2];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            neg4_reg <= cr_neg;
            mag4_reg <= cr_mag;
            mx4_reg  <= mx_next;
        end
    end

    // stage 5: bit length of the largest magnitude
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            neg5_reg   <= neg4_reg;
            mag5_reg   <= mag4_reg;
            bl5_reg    <= bit_len(mx4_reg);
            degen5_reg <= (mx4_reg == '0);
        end
    end

    // stage 6: common shift so the largest lands just below 2^NORM_TOP
    always_comb
    begin
        side6_next       = '0;
        side6_next.valid = v5_reg;
        side6_next.degen = degen5_reg;
        side6_next.neg   = neg5_reg;
        for (int l = 0; l < 3; l++)
        begin
            wide[l] = WW'(mag5_reg[l]);
            if (int'(bl5_reg) > NORM_TOP)
                wide[l] = wide[l] >> (int'(bl5_reg) - NORM_TOP);
            else
                wide[l] = wide[l] << (NORM_TOP - int'(bl5_reg));
            side6_next.mag[l] = wide[l][MAG_W-1:0];
        end
    end

    // stage 7: squares
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < 3; l++)
                sq7_reg[l] <= SQ_W'(side6_reg.mag[l]) * SQ_W'(side6_reg.mag[l]);
        end
    end

    // stage 8: sum of squares
    always_ff @(posedge clk)
    begin
        if (adv)
            sum8_reg <= SUM_W'(sq7_reg[0]) + SUM_W'(sq7_reg[1]) + SUM_W'(sq7_reg[2]);
    end

    assign nv  = side8_reg;
    assign sum = sum8_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/tun_sqrt.sv =====
// ----------------------------------------------------------------------------
// tun_sqrt
// Pipelined digit-by-digit integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tun_sqrt (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  tun_pkg::tun_norm_t           nv_in,
    input  logic [tun_pkg::SUM_W-1:0]    sum_in,
    output tun_pkg::tun_norm_t           nv_out,
    output logic [tun_pkg::ROOT_W-1:0]   root_out
);
    import tun_pkg::*;

    tun_norm_t         side_reg [ROOT_W];
    logic [SUM_W-1:0]  rad_reg  [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];

    for (genvar i = 0; i < ROOT_W; i++)
    begin : g_step
        tun_norm_t         side_prev;
        logic [SUM_W-1:0]  rad_prev;
        logic [REM_W-1:0]  rem_prev, rem_sh, trial, rem_next;
        logic [ROOT_W-1:0] root_prev, root_next;
        logic              ge;

        if (i == 0)
        begin : g_first
            assign side_prev = nv_in;
            assign rad_prev  = sum_in;
            assign rem_prev  = '0;
            assign root_prev = '0;
        end
        else
        begin : g_chain
            assign side_prev = side_reg[i-1];
            assign rad_prev  = rad_reg[i-1];
            assign rem_prev  = rem_reg[i-1];
            assign root_prev = root_reg[i-1];
        end

        // bring down two radicand bits, try root*4+1
        always_comb
        begin
            rem_sh    = {rem_prev[REM_W-3:0], rad_prev[SUM_W-1 -: 2]};
            trial     = REM_W'({root_prev, 2'b01});
            ge        = (rem_sh >= trial);
            rem_next  = ge ? rem_sh - trial : rem_sh;
            root_next = {root_prev[ROOT_W-2:0], ge};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                side_reg[i] <= '0;
            else if (adv)
                side_reg[i] <= side_prev;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rad_reg[i]  <= rad_prev << 2;
                rem_reg[i]  <= rem_next;
                root_reg[i] <= root_next;
            end
        end
    end

    assign nv_out   = side_reg[ROOT_W-1];
    assign root_out = root_reg[ROOT_W-1];

endmodule

`default_nettype wire

// ===== hw/rtl/tun_div.sv =====
// ----------------------------------------------------------------------------
// tun_div
// Three-lane pipelined restoring divider, one quotient bit per stage,
// rounding half up on the magnitude.
// ----------------------------------------------------------------------------
`default_nettype none

module tun_div #(
    parameter int FRAC_BITS = 14
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          adv,
    input  tun_pkg::tun_norm_t            nv_in,
    input  logic [tun_pkg::ROOT_W-1:0]    len_in,
    output logic                          q_valid,
    output logic                          q_degen,
    output logic [2:0]                    q_neg,
    output logic [2:0][FRAC_BITS:0]       q_mag
);
    import tun_pkg::*;

    localparam int STEPS = FRAC_BITS + 1;
    localparam int QW    = FRAC_BITS + 1;
    localparam int NW    = MAG_W + FRAC_BITS + 1;

    logic                  valid_reg [STEPS];
    logic                  degen_reg [STEPS];
    logic [2:0]            neg_reg   [STEPS];
    logic [ROOT_W-1:0]     len_reg   [STEPS];
    logic [2:0][NW-1:0]    rem_reg   [STEPS];
    logic [2:0][QW-1:0]    q_reg     [STEPS];

    for (genvar i = 0; i < STEPS; i++)
    begin : g_step
        logic               valid_prev, degen_prev;
        logic [2:0]         neg_prev;
        logic [ROOT_W-1:0]  len_prev;
        logic [2:0][NW-1:0] rem_prev, rem_next;
        logic [2:0][QW-1:0] q_prev, q_next;
        logic [NW-1:0]      dvs;

        if (i == 0)
        begin : g_first
            // numerator: magnitude scaled by 2^FRAC_BITS plus half the length
            assign valid_prev = nv_in.valid;
            assign degen_prev = nv_in.degen;
            assign neg_prev   = nv_in.neg;
            assign len_prev   = len_in;
            assign q_prev     = '0;
            for (genvar l = 0; l < 3; l++)
            begin : g_lane
                assign rem_prev[l] = (NW'(nv_in.mag[l]) << FRAC_BITS) + NW'(len_in >> 1);
            end
        end
        else
        begin : g_chain
            assign valid_prev = valid_reg[i-1];
            assign degen_prev = degen_reg[i-1];
            assign neg_prev   = neg_reg[i-1];
            assign len_prev   = len_reg[i-1];
            assign rem_prev   = rem_reg[i-1];
            assign q_prev     = q_reg[i-1];
        end

        // trial subtract of the shifted divisor in each lane
        always_comb
        begin
            dvs = NW'(len_prev) << (FRAC_BITS - i);
            for (int l = 0; l < 3; l++)
            begin
                if (rem_prev[l] >= dvs)
                begin
                    rem_next[l] = rem_prev[l] - dvs;
                    q_next[l]   = q_prev[l] | (QW'(1) << (FRAC_BITS - i));
                end
                else
                begin
                    rem_next[l] = rem_prev[l];
                    q_next[l]   = q_prev[l];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i] <= 1'b0;
            else if (adv)
                valid_reg[i] <= valid_prev;
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                degen_reg[i] <= degen_prev;
                neg_reg[i]   <= neg_prev;
                len_reg[i]   <= len_prev;
                rem_reg[i]   <= rem_next;
                q_reg[i]     <= q_next;
            end
        end
    end

    assign q_valid = valid_reg[STEPS-1];
    assign q_degen = degen_reg[STEPS-1];
    assign q_neg   = neg_reg[STEPS-1];
    assign q_mag   = q_reg[STEPS-1];

endmodule

`default_nettype wire

// ===== hw/rtl/triangle_unit_normal.sv =====
// Pipeline stages from input transaction to result:
//   3 cross product, 5 normalize, 31 square root (one bit per stage),
//   FRAC_BITS + 1 divide (one quotient bit per stage), 1 output register.
// Throughput: one triangle per cycle; a stalled output freezes the whole pipeline.
// Reset: asynchronous active low, clears all valid bits and the tun_norm_t side data
//   registers; all other registers are not reset.
// ----------------------------------------------------------------------------
// triangle_unit_normal
// Unit surface normal of a triangle as signed Q2.FRAC_BITS components, with a
// degenerate flag for a zero-length cross product.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_unit_normal #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_BITS-1:0]  a_x,
    input  logic signed [COORD_BITS-1:0]  a_y,
    input  logic signed [COORD_BITS-1:0]  a_z,
    input  logic signed [COORD_BITS-1:0]  b_x,
    input  logic signed [COORD_BITS-1:0]  b_y,
    input  logic signed [COORD_BITS-1:0]  b_z,
    input  logic signed [COORD_BITS-1:0]  c_x,
    input  logic signed [COORD_BITS-1:0]  c_y,
    input  logic signed [COORD_BITS-1:0]  c_z,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [FRAC_BITS+1:0]   unit_x,
    output logic signed [FRAC_BITS+1:0]   unit_y,
    output logic signed [FRAC_BITS+1:0]   unit_z,
    output logic                          degenerate
);
    import tun_pkg::*;

    localparam int XW = 2 * COORD_BITS + 3;
    localparam int UW = FRAC_BITS + 2;

    logic                   adv;
    logic                   cr_valid;
    logic [2:0]             cr_neg;
    logic [2:0][XW-1:0]     cr_mag;
    tun_norm_t              nv_norm, nv_root;
    logic [SUM_W-1:0]       sum;
    logic [ROOT_W-1:0]      root;
    logic                   q_valid, q_degen;
    logic [2:0]             q_neg;
    logic [2:0][FRAC_BITS:0] q_mag;
    logic [2:0][UW-1:0]     unit_next, unit_reg;
    logic                   out_valid_reg, degen_reg;

    // whole pipeline advances unless a result is held at the output
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    tun_cross #(.COORD_BITS(COORD_BITS)) u_cross (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_valid (in_valid),
        .a_x      (a_x),
        .a_y      (a_y),
        .a_z      (a_z),
        .b_x      (b_x),
        .b_y      (b_y),
        .b_z      (b_z),
        .c_x      (c_x),
        .c_y      (c_y),
        .c_z      (c_z),
        .cr_valid (cr_valid),
        .cr_neg   (cr_neg),
        .cr_mag   (cr_mag)
    );

    tun_norm #(.COORD_BITS(COORD_BITS)) u_norm (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .cr_valid (cr_valid),
        .cr_neg   (cr_neg),
        .cr_mag   (cr_mag),
        .nv       (nv_norm),
        .sum      (sum)
    );

    tun_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .nv_in    (nv_norm),
        .sum_in   (sum),
        .nv_out   (nv_root),
        .root_out (root)
    );

    tun_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv),
        .nv_in   (nv_root),
        .len_in  (root),
        .q_valid (q_valid),
        .q_degen (q_degen),
        .q_neg   (q_neg),
        .q_mag   (q_mag)
    );

    // apply sign, force zero for a degenerate triangle
    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            if (q_degen)
                unit_next[l] = '0;
            else if (q_neg[l])
                unit_next[l] = UW'(-UW'(q_mag[l]));
            else
                unit_next[l] = UW'(q_mag[l]);
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= q_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            unit_reg  <= unit_next;
            degen_reg <= q_degen;
        end
    end

    assign out_valid  = out_valid_reg;
    assign unit_x     = unit_reg[0];
    assign unit_y     = unit_reg[1];
    assign unit_z     = unit_reg[2];
    assign degenerate = degen_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/tun_checker.sv =====
// ----------------------------------------------------------------------------
// tun_checker
// Port-level checks of the triangle unit normal block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tun_checker #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 14
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic signed [COORD_BITS-1:0]  a_x,
    input  logic signed [COORD_BITS-1:0]  a_y,
    input  logic signed [COORD_BITS-1:0]  a_z,
    input  logic signed [COORD_BITS-1:0]  b_x,
    input  logic signed [COORD_BITS-1:0]  b_y,
    input  logic signed [COORD_BITS-1:0]  b_z,
    input  logic signed [COORD_BITS-1:0]  c_x,
    input  logic signed [COORD_BITS-1:0]  c_y,
    input  logic signed [COORD_BITS-1:0]  c_z,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic signed [FRAC_BITS+1:0]   unit_x,
    input  logic signed [FRAC_BITS+1:0]   unit_y,
    input  logic signed [FRAC_BITS+1:0]   unit_z,
    input  logic                          degenerate
);
    localparam int ONE = 1 << FRAC_BITS;

    // no result shown while in reset
    a_reset_idle: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result valid during reset");

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(unit_x) && $stable(unit_y)
            && $stable(unit_z) && $stable(degenerate))
        else $error("result transaction changed while stalled");

    // an empty output stage never blocks the input
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input blocked with empty output");

    // degenerate triangle gives zero components
    a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> unit_x == 0 && unit_y == 0 && unit_z == 0)
        else $error("degenerate result with nonzero components");

    // components stay within plus and minus one
    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !degenerate |->
            unit_x <= ONE && unit_x >= -ONE && unit_y <= ONE && unit_y >= -ONE
            && unit_z <= ONE && unit_z >= -ONE)
        else $error("component outside unit range");

endmodule

bind triangle_unit_normal tun_checker #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
) u_tun_checker (.*);

`default_nettype wire

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Regression for triangle_unit_normal: directed and random triangles are sent
// through the valid/ready input; every result is compared with a normal
// computed in the testbench, under random idling and a long output hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;

    localparam int CB       = 16;
    localparam int FB       = 14;
    localparam int UB       = FB + 2;
    localparam int TOP      = 30;
    localparam int LATENCY  = 41 + FB;
    localparam int N_RANDOM = 400;

    typedef struct {
        logic signed [CB-1:0] v [9];
    } tri_t;

    typedef struct {
        logic [UB-1:0] ux;
        logic [UB-1:0] uy;
        logic [UB-1:0] uz;
        logic          degen;
    } normal_t;

    // integer square root, bit by bit
    function automatic longint unsigned root64(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n   -= res + bitv;
                res  = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    // unit normal of (a-b) x (a-c)
    function automatic normal_t unit_normal(tri_t t);
        normal_t         r;
        longint          e [3];
        longint          f [3];
        longint          cr [3];
        longint unsigned mag [3];
        logic            neg [3];
        longint unsigned mx, sum, len, q, v;
        int              bl;
        for (int i = 0; i < 3; i++)
        begin
            e[i] = longint'(t.v[i]) - longint'(t.v[3 + i]);
            f[i] = longint'(t.v[i]) - longint'(t.v[6 + i]);
        end
        cr[0] = e[1] * f[2] - e[2] * f[1];
        cr[1] = e[2] * f[0] - e[0] * f[2];
        cr[2] = e[0] * f[1] - e[1] * f[0];
        mx = 0;
        for (int i = 0; i < 3; i++)
        begin
            neg[i] = cr[i] < 0;
            mag[i] = neg[i] ? -cr[i] : cr[i];
            if (mag[i] > mx)
                mx = mag[i];
        end
        r = '{default: '0};
        if (mx == 0)
        begin
            r.degen = 1'b1;
            return r;
        end
        bl = 0;
        while ((mx >> bl) != 0)
            bl++;
        sum = 0;
        for (int i = 0; i < 3; i++)
        begin
            if (bl > TOP)
                mag[i] >>= (bl - TOP);
            else if (bl < TOP)
                mag[i] <<= (TOP - bl);
            sum += mag[i] * mag[i];
        end
        len = root64(sum);
        for (int i = 0; i < 3; i++)
        begin
            q = ((mag[i] << FB) + (len >> 1)) / len;
            v = neg[i] ? -q : q;
            if (i == 0) r.ux = v[UB-1:0];
            if (i == 1) r.uy = v[UB-1:0];
            if (i == 2) r.uz = v[UB-1:0];
        end
        return r;
    endfunction

    // queue of expected normals, checked in order
    class normal_scoreboard;
        normal_t pending [$];
        int      errors = 0;

        function void note_triangle(tri_t t);
            pending.push_back(unit_normal(t));
        endfunction

        function void check_normal(normal_t got);
            normal_t exp_n;
            if (pending.size() == 0)
            begin
                $error("unexpected result transaction");
                errors++;
                return;
            end
            exp_n = pending.pop_front();
            if (got.ux !== exp_n.ux)
            begin
                $error("unit_x expected %0h actual %0h", exp_n.ux, got.ux);
                errors++;
            end
            if (got.uy !== exp_n.uy)
            begin
                $error("unit_y expected %0h actual %0h", exp_n.uy, got.uy);
                errors++;
            end
            if (got.uz !== exp_n.uz)
            begin
                $error("unit_z expected %0h actual %0h", exp_n.uz, got.uz);
                errors++;
            end
            if (got.degen !== exp_n.degen)
            begin
                $error("degenerate expected %0b actual %0b", exp_n.degen, got.degen);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [CB-1:0] a_x = '0, a_y = '0, a_z = '0;
    logic signed [CB-1:0] b_x = '0, b_y = '0, b_z = '0;
    logic signed [CB-1:0] c_x = '0, c_y = '0, c_z = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [UB-1:0] unit_x, unit_y, unit_z;
    logic degenerate;

    normal_scoreboard sb = new();
    logic idle_on   = 1'b1;
    logic hold_req  = 1'b0;
    logic send_done = 1'b0;

    triangle_unit_normal u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .a_x(a_x), .a_y(a_y), .a_z(a_z),
        .b_x(b_x), .b_y(b_y), .b_z(b_z),
        .c_x(c_x), .c_y(c_y), .c_z(c_z),
        .out_valid(out_valid), .out_ready(out_ready),
        .unit_x(unit_x), .unit_y(unit_y), .unit_z(unit_z),
        .degenerate(degenerate)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // send one triangle, with an optional random gap in front;
    // valid stays high into the next transaction when there is no gap
    task automatic send_triangle(tri_t t);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid <= 1'b1;
        a_x <= t.v[0]; a_y <= t.v[1]; a_z <= t.v[2];
        b_x <= t.v[3]; b_y <= t.v[4]; b_z <= t.v[5];
        c_x <= t.v[6]; c_y <= t.v[7]; c_z <= t.v[8];
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_triangle(t);
    endtask

    function automatic logic signed [CB-1:0] rand_coord(int mode);
        case (mode)
            0: return CB'($urandom);
            1: return CB'($urandom_range(0, 15)) - 8;
            2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
            default: return CB'($urandom_range(0, 2047)) - 1024;
        endcase
    endfunction

    // stimulus
    initial
    begin
        tri_t t;
        int   mode;
        rst_n <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // coincident vertices
        t.v = '{default: '0};
        send_triangle(t);
        // collinear vertices
        t.v = '{0, 0, 0, 1, 2, 3, 2, 4, 6};
        send_triangle(t);
        // axis-aligned triangles
        t.v = '{0, 0, 0, 1, 0, 0, 0, 1, 0};
        send_triangle(t);
        t.v = '{0, 0, 0, 0, 1, 0, 1, 0, 0};
        send_triangle(t);
        t.v = '{0, 0, 0, 0, 0, 1, 1, 0, 0};
        send_triangle(t);
        // field extremes, largest products
        t.v = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
                16'sh7fff, 16'sh8000, 16'sh8000};
        send_triangle(t);
        t.v = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000,
                16'sh8000, 16'sh7fff, 16'sh7fff};
        send_triangle(t);
        t.v = '{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
                16'sh8000, 16'sh8000, 16'sh7fff};
        send_triangle(t);
        t.v = '{default: 16'sh7fff};
        send_triangle(t);
        t.v = '{-1, -1, -1, 0, -1, -1, -1, 0, -1};
        send_triangle(t);
        // random part, with a long output hold-off partway
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == 150)
                hold_req <= 1'b1;
            if (n == 320)
                idle_on = 1'b0;
            mode = $urandom_range(0, 3);
            for (int i = 0; i < 9; i++)
                t.v[i] = rand_coord(mode);
            // occasional collinear triangle
            if ($urandom_range(0, 15) == 0)
                for (int i = 0; i < 3; i++)
                    t.v[6 + i] = 2 * t.v[3 + i] - t.v[i];
            send_triangle(t);
        end
        in_valid  <= 1'b0;
        send_done <= 1'b1;
    end

    // receiver: random stalls and one long hold-off
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  <= 1'b0;
                out_ready <= 1'b0;
                repeat (300) @(posedge clk);
            end
            else if (idle_on && out_ready && $urandom_range(0, 4) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(0, 4)) @(posedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_normal('{unit_x, unit_y, unit_z, degenerate});
    end

    // end of run
    initial
    begin
        wait (send_done);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("triangle_unit_normal regression: pass");
        else
            $display("triangle_unit_normal regression: fail");
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("triangle_unit_normal regression: fail");
        $finish;
    end

endmodule
